[sv/akcd_pkg.sv]
// Package for the actuator kick / cooldown driver.
// Holds the shared types, command and register codes and reset values.
// No dependencies.
package akcd_pkg;

  // Actuator modes.
  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_WIND  = 2'd1,
    MODE_HYDRO = 2'd2,
    MODE_MIST  = 2'd3
  } mode_t;

  // Item kinds. The spare kind is handled like a time update.
  localparam logic [1:0] KIND_TIME      = 2'd0;
  localparam logic [1:0] KIND_MOTOR_ON  = 2'd1;
  localparam logic [1:0] KIND_MOTOR_OFF = 2'd2;
  localparam logic [1:0] KIND_SPARE     = 2'd3;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KICK_MS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_DUTY  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_DUTY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NEB_DUTY  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COOL_MS   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 3'd6;

  localparam int unsigned CFG_DATA_W = 16;

  // Reset values of the configuration registers.
  localparam logic [15:0] RST_KICK_MS   = 16'd300;
  localparam logic [7:0]  RST_RUN_DUTY  = 8'd100;
  localparam logic [7:0]  RST_FULL_DUTY = 8'd255;
  localparam logic [7:0]  RST_NEB_DUTY  = 8'd255;
  localparam logic [15:0] RST_COOL_MS   = 16'd5000;
  localparam logic [15:0] RST_TIMEOUT   = 16'd2500;

  // Valid motor-on percent range and payload lengths.
  localparam logic [7:0] PCT_MAX     = 8'd100;
  localparam logic [7:0] LEN_ON      = 8'd1;
  localparam logic [7:0] LEN_OFF     = 8'd0;

  typedef struct packed {
    mode_t       mode;
    logic [15:0] kick_ms;
    logic [7:0]  run_duty;
    logic [7:0]  full_duty;
    logic [7:0]  neb_duty;
    logic [15:0] cool_ms;
    logic [15:0] timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] now_ms;
    logic [7:0]  percent;
    logic [7:0]  payload_length;
  } item_t;

  typedef struct packed {
    logic [6:0]  req_pct;
    logic        cmd_seen;
    logic [31:0] last_cmd_time;
    logic        motor_active;
    logic        kick_active;
    logic [31:0] kick_start;
    logic        mist_active;
    logic        cool_active;
    logic [31:0] stop_time;
    logic [7:0]  duty;
  } state_t;

  typedef struct packed {
    logic [7:0] drive_duty;
    logic       duty_changed;
    logic       actuator_on;
    logic       kicking;
    logic       cooling_down;
    logic       command_rejected;
  } result_t;

endpackage

[sv/actuator_kick_cooldown_driver.sv]
// Top level of the actuator kick / cooldown driver: input register, state
// register, result register. Depends on akcd_pkg, akcd_cfg_regs and akcd_update.
//
//   Port group | Direction | Handshake            | Moves
//   in_*       | in        | in_valid / in_stall   | one time stamp or command request
//   out_*      | out       | out_valid / out_stall | one result per request
//   cfg_*      | in        | cfg_valid / cfg_ready | one register write
//
// A request is registered on acceptance and evaluated from the input register;
// its result is loaded into the output register when that register advances,
// one request per cycle sustained without an output stall. The state update
// is a single pass of compares and 32-bit time differences between the input
// and result registers. Reset clears the actuator state and loads the register
// defaults. A stalled output holds its result; the input register stalls only
// while it is full and the output register is full and stalled.
module actuator_kick_cooldown_driver (
  input  logic                             clk,
  input  logic                             rst_n,

  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_kind,
  input  logic [31:0]                      in_now_ms,
  input  logic [7:0]                       in_percent,
  input  logic [7:0]                       in_payload_length,

  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [7:0]                       out_drive_duty,
  output logic                             out_duty_changed,
  output logic                             out_actuator_on,
  output logic                             out_kicking,
  output logic                             out_cooling_down,
  output logic                             out_command_rejected,

  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [akcd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [akcd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import akcd_pkg::*;

  cfg_t    cfg;
  item_t   item_r;
  logic    item_valid_r;
  state_t  state_r;
  state_t  state_nxt;
  result_t res_nxt;
  result_t res_r;
  logic    out_valid_r;
  logic    advance;

  akcd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  akcd_update u_update (
    .cfg  (cfg),
    .item (item_r),
    .cur  (state_r),
    .nxt  (state_nxt),
    .res  (res_nxt)
  );

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = item_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (!in_stall) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r.kind           <= in_kind;
      item_r.now_ms         <= in_now_ms;
      item_r.percent        <= in_percent;
      item_r.payload_length <= in_payload_length;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (item_valid_r && advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= item_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid_r && advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_drive_duty       = res_r.drive_duty;
  assign out_duty_changed     = res_r.duty_changed;
  assign out_actuator_on      = res_r.actuator_on;
  assign out_kicking          = res_r.kicking;
  assign out_cooling_down     = res_r.cooling_down;
  assign out_command_rejected = res_r.command_rejected;

  // A kick only runs while the motor is marked running.
  a_kick_needs_motor: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.kick_active |-> state_r.motor_active)
    else $error("kick active without motor running");

  // The nebulizer is never running and cooling down at once.
  a_mist_cool_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(state_r.mist_active && state_r.cool_active))
    else $error("nebulizer running during cooldown");

  // A nonzero request always comes with a command that is still marked as seen.
  a_req_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.req_pct != 7'd0) |-> state_r.cmd_seen)
    else $error("request held without a live command");

  // An evaluated request shows up as a valid result in the next cycle.
  a_eval_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (item_valid_r && advance) |=> out_valid_r)
    else $error("evaluated request lost before the output register");

  // The input side only stalls with a request waiting in the input register.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (item_valid_r && out_valid_r))
    else $error("input stalled with nothing pending");

endmodule

[sv/akcd_cfg_regs.sv]
// Configuration register bank of the actuator driver.
// Depends on akcd_pkg for the register indexes, reset values and cfg_t.
module akcd_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [akcd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [akcd_pkg::CFG_DATA_W-1:0]  cfg_data,
  output akcd_pkg::cfg_t                   cfg
);
  import akcd_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode       <= MODE_NONE;
      cfg_r.kick_ms    <= RST_KICK_MS;
      cfg_r.run_duty   <= RST_RUN_DUTY;
      cfg_r.full_duty  <= RST_FULL_DUTY;
      cfg_r.neb_duty   <= RST_NEB_DUTY;
      cfg_r.cool_ms    <= RST_COOL_MS;
      cfg_r.timeout_ms <= RST_TIMEOUT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MODE:      cfg_r.mode       <= mode_t'(cfg_data[1:0]);
        REG_KICK_MS:   cfg_r.kick_ms    <= cfg_data;
        REG_RUN_DUTY:  cfg_r.run_duty   <= cfg_data[7:0];
        REG_FULL_DUTY: cfg_r.full_duty  <= cfg_data[7:0];
        REG_NEB_DUTY:  cfg_r.neb_duty   <= cfg_data[7:0];
        REG_COOL_MS:   cfg_r.cool_ms    <= cfg_data;
        REG_TIMEOUT:   cfg_r.timeout_ms <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

[sv/akcd_update.sv]
// Per-item update logic: command check, timeout, and the mode's duty update.
// Purely combinational; depends on akcd_pkg for the item, state and result types.
module akcd_update (
  input  akcd_pkg::cfg_t    cfg,
  input  akcd_pkg::item_t   item,
  input  akcd_pkg::state_t  cur,
  output akcd_pkg::state_t  nxt,
  output akcd_pkg::result_t res
);
  import akcd_pkg::*;

  logic        has_act;
  logic        rejected;
  logic        pct_ok;
  logic [31:0] cmd_age;
  logic [31:0] kick_age;
  logic [31:0] stop_age;
  state_t      s;

  assign has_act  = (cfg.mode != MODE_NONE);
  assign pct_ok   = (item.percent != 8'd0) && (item.percent <= PCT_MAX);
  assign kick_age = item.now_ms - cur.kick_start;
  assign stop_age = item.now_ms - cur.stop_time;

  always_comb begin
    s        = cur;
    rejected = 1'b0;
    cmd_age  = 32'd0;

    if (item.kind == KIND_MOTOR_ON) begin
      if (!has_act || item.payload_length != LEN_ON || !pct_ok) begin
        rejected = 1'b1;
      end else begin
        s.req_pct       = item.percent[6:0];
        s.last_cmd_time = item.now_ms;
        s.cmd_seen      = 1'b1;
      end
    end else if (item.kind == KIND_MOTOR_OFF) begin
      if (!has_act || item.payload_length != LEN_OFF) begin
        rejected = 1'b1;
      end else begin
        s.req_pct       = 7'd0;
        s.last_cmd_time = item.now_ms;
        s.cmd_seen      = 1'b1;
      end
    end

    if (!has_act) begin
      s.duty = 8'd0;
    end else begin
      // The timeout is measured from the command time as it stands after
      // this item's own command, so a zero timeout clears it at once.
      cmd_age = item.now_ms - s.last_cmd_time;
      if (s.cmd_seen && cmd_age >= {16'd0, cfg.timeout_ms}) begin
        s.cmd_seen = 1'b0;
        s.req_pct  = 7'd0;
      end

      if (cfg.mode == MODE_MIST) begin
        if (s.req_pct == 7'd0) begin
          if (s.mist_active) begin
            s.mist_active = 1'b0;
            s.cool_active = 1'b1;
            s.stop_time   = item.now_ms;
            s.duty        = 8'd0;
          end
        end else if (!s.mist_active) begin
          if (!(s.cool_active && stop_age < {16'd0, cfg.cool_ms})) begin
            s.cool_active = 1'b0;
            s.mist_active = 1'b1;
            s.duty        = cfg.neb_duty;
          end
        end
      end else begin
        if (s.req_pct == 7'd0) begin
          if (s.motor_active) begin
            s.motor_active = 1'b0;
            s.kick_active  = 1'b0;
            s.duty         = 8'd0;
          end
        end else if (!s.motor_active && cfg.mode == MODE_WIND) begin
          // Wind motor start: full-duty kick from this time stamp.
          s.motor_active = 1'b1;
          s.kick_active  = 1'b1;
          s.kick_start   = item.now_ms;
          s.duty         = cfg.full_duty;
        end else begin
          s.motor_active = 1'b1;
          if (cfg.mode == MODE_WIND) begin
            if (!(s.kick_active && kick_age < {16'd0, cfg.kick_ms})) begin
              s.kick_active = 1'b0;
              s.duty        = cfg.run_duty;
            end
          end else begin
            s.duty = cfg.full_duty;
          end
        end
      end
    end

    nxt = s;

    res.drive_duty       = s.duty;
    res.duty_changed     = (s.duty != cur.duty);
    res.actuator_on      = (cfg.mode == MODE_MIST) ? s.mist_active :
                           (has_act ? s.motor_active : 1'b0);
    res.kicking          = (cfg.mode == MODE_WIND) && s.kick_active;
    res.cooling_down     = (cfg.mode == MODE_MIST) && s.cool_active;
    res.command_rejected = rejected;
  end

endmodule
